// File: rtl/reorder_buffer_rename_commit_assert.svh
// assertion macros for the reorder buffer checker
`ifndef REORDER_BUFFER_RENAME_COMMIT_ASSERT_SVH
`define REORDER_BUFFER_RENAME_COMMIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define RRC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RRC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rrc_pkg.sv
// package for the reorder buffer: status codes, default sizes and stream widths
`timescale 1ns / 1ps

package rrc_pkg;

	localparam int ENTRY_COUNT_DEF = 16;
	localparam int REG_COUNT_DEF   = 32;
	localparam int PC_BITS_DEF     = 16;

	// packed stream widths, rounded up to whole bytes
	localparam int S_DATA_BITS = 88;
	localparam int M_DATA_BITS = 104;

	typedef enum logic [2:0] {
		ST_INVALID = 3'd0,
		ST_EXEC    = 3'd1,
		ST_DONE    = 3'd2,
		ST_RESET   = 3'd3,
		ST_DUMMY   = 3'd4
	} entry_status_t;

endpackage

// File: rtl/reorder_buffer_rename_commit.sv
// reorder buffer with register rename tags, writeback, allocation and commit
// each item is taken into the input register, and its result item is held in the output register
// throughput: one item per cycle while the output is not stalled; the whole ring and register file update once per item
// the output register lets a new item enter while a finished result still waits
// reset (arst_n low): pointers, entry status, tags, pending bits and register values clear
// entry payload (dest, value, next pc) is written at allocation and needs no reset
`timescale 1ns / 1ps

module reorder_buffer_rename_commit #(
	parameter int ENTRY_COUNT = rrc_pkg::ENTRY_COUNT_DEF,
	parameter int REG_COUNT   = rrc_pkg::REG_COUNT_DEF,
	parameter int PC_BITS     = rrc_pkg::PC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// from bit 0: dispatch_valid, dispatch_dummy, dispatch_dest[5], dispatch_pred_pc[16],
	// wb_valid, wb_entry[4], wb_value[32], wb_next_pc[16], src_a_reg[5], src_b_reg[5], pad
	input  logic [rrc_pkg::S_DATA_BITS-1:0] s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// from bit 0: full_res, alloc_entry[4], src_a_value[32], src_a_pending, src_a_tag[4],
	// src_b_value[32], src_b_pending, src_b_tag[4], dummy_retired, redirect, redirect_pc[16], pad
	output logic [rrc_pkg::M_DATA_BITS-1:0] m_tdata
);

	import rrc_pkg::*;

	localparam int EW = $clog2(ENTRY_COUNT);
	localparam int RW = $clog2(REG_COUNT);

	// input register
	logic                   valid_s1;
	logic [S_DATA_BITS-1:0] in_s1;

	// output register
	logic                   out_valid_q;
	logic [M_DATA_BITS-1:0] out_data_q;

	// ring and register file state
	entry_status_t          status_q   [ENTRY_COUNT];
	logic [RW-1:0]          ent_dest_q [ENTRY_COUNT];
	logic [31:0]            ent_val_q  [ENTRY_COUNT];
	logic [PC_BITS-1:0]     ent_npc_q  [ENTRY_COUNT];
	logic [31:0]            arch_val_q [REG_COUNT];
	logic                   arch_pend_q[REG_COUNT];
	logic [EW-1:0]          arch_tag_q [REG_COUNT];
	logic [EW-1:0]          alloc_ptr_q;
	logic [EW-1:0]          retire_ptr_q;

	// next state
	entry_status_t          status_n   [ENTRY_COUNT];
	logic [RW-1:0]          ent_dest_n [ENTRY_COUNT];
	logic [31:0]            ent_val_n  [ENTRY_COUNT];
	logic [PC_BITS-1:0]     ent_npc_n  [ENTRY_COUNT];
	logic [31:0]            arch_val_n [REG_COUNT];
	logic                   arch_pend_n[REG_COUNT];
	logic [EW-1:0]          arch_tag_n [REG_COUNT];
	logic [EW-1:0]          alloc_ptr_n;
	logic [EW-1:0]          retire_ptr_n;

	// unpacked fields of the item in the input register
	logic        dispatch_valid;
	logic        dispatch_dummy;
	logic [4:0]  dispatch_dest;
	logic [15:0] dispatch_pred_pc;
	logic        wb_valid;
	logic [3:0]  wb_entry;
	logic [31:0] wb_value;
	logic [15:0] wb_next_pc;
	logic [4:0]  src_reg [2];

	logic                  advance;
	logic                  work;
	logic [EW+3:0]         wb_ext;
	logic [EW-1:0]         wb_idx;
	logic [PC_BITS+15:0]   wb_npc_ext;
	logic [PC_BITS+15:0]   pred_pc_ext;
	logic [PC_BITS-1:0]    wb_npc;
	logic [RW+4:0]         dest_ext;
	logic [RW-1:0]         dest_idx;
	logic [RW+4:0]         src_ext [2];
	logic [RW-1:0]         src_idx [2];
	logic [EW-1:0]         src_t   [2];
	logic [EW+3:0]         tag_ext [2];
	logic [EW+3:0]         alloc_ext;
	logic [PC_BITS+15:0]   rpc_ext;
	logic [RW-1:0]         cm_dest;

	logic                  full_res;
	logic                  do_alloc;
	logic [31:0]           src_value [2];
	logic                  src_pend  [2];
	logic [3:0]            src_tag   [2];
	logic                  dummy_retired;
	logic                  redirect;
	logic [PC_BITS-1:0]    redirect_npc;
	logic [M_DATA_BITS-1:0] out_d;

	assign advance  = !out_valid_q || m_tready;
	assign work     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign dispatch_valid   = in_s1[0];
	assign dispatch_dummy   = in_s1[1];
	assign dispatch_dest    = in_s1[6:2];
	assign dispatch_pred_pc = in_s1[22:7];
	assign wb_valid         = in_s1[23];
	assign wb_entry         = in_s1[27:24];
	assign wb_value         = in_s1[59:28];
	assign wb_next_pc       = in_s1[75:60];
	assign src_reg[0]       = in_s1[80:76];
	assign src_reg[1]       = in_s1[85:81];

	assign wb_ext      = {{EW{1'b0}}, wb_entry};
	assign wb_idx      = wb_ext[EW-1:0];
	assign wb_npc_ext  = {{PC_BITS{1'b0}}, wb_next_pc};
	assign wb_npc      = wb_npc_ext[PC_BITS-1:0];
	assign pred_pc_ext = {{PC_BITS{1'b0}}, dispatch_pred_pc};
	assign dest_ext    = {{RW{1'b0}}, dispatch_dest};
	assign dest_idx    = dest_ext[RW-1:0];
	assign alloc_ext   = {4'd0, alloc_ptr_q};

	assign full_res = status_q[alloc_ptr_q] != ST_INVALID;
	assign do_alloc = dispatch_valid && !full_res;

	always_comb begin
		status_n      = status_q;
		ent_dest_n    = ent_dest_q;
		ent_val_n     = ent_val_q;
		ent_npc_n     = ent_npc_q;
		arch_val_n    = arch_val_q;
		arch_pend_n   = arch_pend_q;
		arch_tag_n    = arch_tag_q;
		alloc_ptr_n   = alloc_ptr_q;
		retire_ptr_n  = retire_ptr_q;
		dummy_retired = 1'b0;
		redirect      = 1'b0;
		redirect_npc  = '0;
		cm_dest       = '0;

		// writeback: only an executing entry takes a result
		if (wb_valid && wb_ext < ENTRY_COUNT && status_q[wb_idx] == ST_EXEC) begin
			if (ent_dest_q[wb_idx] != '0) begin
				ent_val_n[wb_idx] = wb_value;
			end
			if (wb_npc != ent_npc_q[wb_idx]) begin
				status_n[wb_idx]  = ST_RESET;
				ent_npc_n[wb_idx] = wb_npc;
			end else begin
				status_n[wb_idx] = ST_DONE;
			end
		end

		// source reads see the file before allocation, forward done producers
		for (int k = 0; k < 2; k++) begin
			src_ext[k]   = {{RW{1'b0}}, src_reg[k]};
			src_idx[k]   = src_ext[k][RW-1:0];
			src_t[k]     = arch_tag_q[src_idx[k]];
			src_value[k] = '0;
			src_pend[k]  = 1'b0;
			tag_ext[k]   = '0;
			if (src_ext[k] != '0 && src_ext[k] < REG_COUNT) begin
				src_value[k] = arch_val_q[src_idx[k]];
				if (arch_pend_q[src_idx[k]]) begin
					if (status_n[src_t[k]] == ST_DONE) begin
						src_value[k] = ent_val_n[src_t[k]];
					end else begin
						src_pend[k] = 1'b1;
						tag_ext[k]  = {4'd0, src_t[k]};
					end
				end
			end
			src_tag[k] = tag_ext[k][3:0];
		end

		// allocation
		if (do_alloc) begin
			status_n[alloc_ptr_q]  = dispatch_dummy ? ST_DUMMY : ST_EXEC;
			ent_npc_n[alloc_ptr_q] = pred_pc_ext[PC_BITS-1:0];
			ent_val_n[alloc_ptr_q] = '0;
			if (dispatch_dummy || dest_ext >= REG_COUNT) begin
				ent_dest_n[alloc_ptr_q] = '0;
			end else begin
				ent_dest_n[alloc_ptr_q] = dest_idx;
				if (dest_idx != '0) begin
					arch_pend_n[dest_idx] = 1'b1;
					arch_tag_n[dest_idx]  = alloc_ptr_q;
				end
			end
			alloc_ptr_n = (alloc_ptr_q == EW'(ENTRY_COUNT - 1)) ? '0 : alloc_ptr_q + 1'b1;
		end

		// commit of the oldest entry
		cm_dest = ent_dest_n[retire_ptr_q];
		case (status_n[retire_ptr_q])
			ST_DUMMY: begin
				dummy_retired            = 1'b1;
				status_n[retire_ptr_q]   = ST_INVALID;
				retire_ptr_n = (retire_ptr_q == EW'(ENTRY_COUNT - 1)) ? '0 : retire_ptr_q + 1'b1;
			end
			ST_DONE: begin
				if (cm_dest != '0) begin
					arch_val_n[cm_dest] = ent_val_n[retire_ptr_q];
					if (arch_tag_n[cm_dest] == retire_ptr_q) begin
						arch_pend_n[cm_dest] = 1'b0;
						arch_tag_n[cm_dest]  = '0;
					end
				end
				status_n[retire_ptr_q] = ST_INVALID;
				retire_ptr_n = (retire_ptr_q == EW'(ENTRY_COUNT - 1)) ? '0 : retire_ptr_q + 1'b1;
			end
			ST_RESET: begin
				if (cm_dest != '0) begin
					arch_val_n[cm_dest] = ent_val_n[retire_ptr_q];
				end
				redirect     = 1'b1;
				redirect_npc = ent_npc_n[retire_ptr_q];
				// flush: every tag, every entry, both pointers
				for (int r = 0; r < REG_COUNT; r++) begin
					arch_pend_n[r] = 1'b0;
					arch_tag_n[r]  = '0;
				end
				for (int i = 0; i < ENTRY_COUNT; i++) begin
					status_n[i] = ST_INVALID;
				end
				alloc_ptr_n  = '0;
				retire_ptr_n = '0;
			end
			default: begin
			end
		endcase
	end

	assign rpc_ext = {16'd0, redirect_npc};
	assign out_d = {7'd0, rpc_ext[15:0], redirect, dummy_retired,
		src_tag[1], src_pend[1], src_value[1],
		src_tag[0], src_pend[0], src_value[0],
		alloc_ext[3:0], full_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1 <= s_tdata;
		end
		if (work) begin
			out_data_q <= out_d;
			ent_dest_q <= ent_dest_n;
			ent_val_q  <= ent_val_n;
			ent_npc_q  <= ent_npc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				status_q[i] <= ST_INVALID;
			end
			for (int r = 0; r < REG_COUNT; r++) begin
				arch_val_q[r]  <= '0;
				arch_pend_q[r] <= 1'b0;
				arch_tag_q[r]  <= '0;
			end
			alloc_ptr_q  <= '0;
			retire_ptr_q <= '0;
		end else if (work) begin
			status_q     <= status_n;
			arch_val_q   <= arch_val_n;
			arch_pend_q  <= arch_pend_n;
			arch_tag_q   <= arch_tag_n;
			alloc_ptr_q  <= alloc_ptr_n;
			retire_ptr_q <= retire_ptr_n;
		end
	end

endmodule

// File: rtl/rrc_checker.sv
// port-level checker for the reorder buffer, bound to the top level
`timescale 1ns / 1ps
`include "reorder_buffer_rename_commit_assert.svh"

module rrc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rrc_pkg::M_DATA_BITS-1:0] m_tdata
);

	import rrc_pkg::*;

	logic        a_pend;
	logic [3:0]  a_tag;
	logic        b_pend;
	logic [3:0]  b_tag;
	logic        dummy_retired;
	logic        redirect;
	logic [15:0] redirect_pc;
	logic        out_stall;
	logic        a_tag_ok;
	logic        b_tag_ok;

	assign a_pend        = m_tdata[37];
	assign a_tag         = m_tdata[41:38];
	assign b_pend        = m_tdata[74];
	assign b_tag         = m_tdata[78:75];
	assign dummy_retired = m_tdata[79];
	assign redirect      = m_tdata[80];
	assign redirect_pc   = m_tdata[96:81];
	assign out_stall     = m_tvalid && !m_tready;
	assign a_tag_ok      = a_pend || a_tag == 4'd0;
	assign b_tag_ok      = b_pend || b_tag == 4'd0;

	// a stalled result item holds
	`RRC_ASSERT_NEXT(a_out_hold, out_stall, m_tvalid && $stable(m_tdata), "result item changed while stalled")

	// input is only refused behind a stalled result
	`RRC_ASSERT_NOW(a_in_block, !s_tready, out_stall, "input refused with no stalled result")

	// one commit per item: a dummy retire and a flush never coincide
	`RRC_ASSERT_NOW(a_commit_excl, m_tvalid, !(dummy_retired && redirect), "dummy retire and flush in one item")

	`RRC_ASSERT_NOW(a_rpc_idle, m_tvalid && !redirect, redirect_pc == 16'd0, "redirect pc without redirect")

	// a source that is not waiting carries no producer tag
	`RRC_ASSERT_NOW(a_tag_idle, m_tvalid, a_tag_ok && b_tag_ok, "tag set on a source that is not pending")

endmodule

bind reorder_buffer_rename_commit rrc_checker u_rrc_checker (.*);

// File: test/reorder_buffer_rename_commit_tb.sv
// self-checking testbench for the reorder buffer with rename tags and in-order commit
`timescale 1ns / 1ps

module reorder_buffer_rename_commit_tb;
	import rrc_pkg::*;

	localparam int ENTRIES    = ENTRY_COUNT_DEF;
	localparam int REGS       = REG_COUNT_DEF;
	localparam int QUIET_MAX  = 5000;
	localparam int HOLD_LEN   = 100;
	localparam int PHASE_LEN  = 240;
	localparam int FILL_RUN   = 18;

	// input item, packed from bit 0 as on s_tdata
	typedef struct packed {
		logic [1:0]  pad;
		logic [4:0]  src_b_reg;
		logic [4:0]  src_a_reg;
		logic [15:0] wb_next_pc;
		logic [31:0] wb_value;
		logic [3:0]  wb_entry;
		logic        wb_valid;
		logic [15:0] dispatch_pred_pc;
		logic [4:0]  dispatch_dest;
		logic        dispatch_dummy;
		logic        dispatch_valid;
	} rob_cmd_t;

	// result item, packed from bit 0 as on m_tdata
	typedef struct packed {
		logic [6:0]  pad;
		logic [15:0] redirect_pc;
		logic        redirect;
		logic        dummy_retired;
		logic [3:0]  src_b_tag;
		logic        src_b_pending;
		logic [31:0] src_b_value;
		logic [3:0]  src_a_tag;
		logic        src_a_pending;
		logic [31:0] src_a_value;
		logic [3:0]  alloc_entry;
		logic        full_res;
	} rob_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_BITS-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_BITS-1:0] m_tdata;

	reorder_buffer_rename_commit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the ring and the register file
	entry_status_t rob_status [ENTRIES];
	logic [4:0]    rob_dest [ENTRIES];
	logic [31:0]   rob_value [ENTRIES];
	logic [15:0]   rob_npc [ENTRIES];
	logic [31:0]   reg_value [REGS];
	logic          reg_pending [REGS];
	logic [3:0]    reg_tag [REGS];
	logic [3:0]    alloc_ptr;
	logic [3:0]    retire_ptr;

	rob_cmd_t  pending_cmds [$];
	rob_view_t expected_views [$];

	int errors = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int items_taken = 0;
	int flushes = 0;
	int dummy_retires = 0;
	int refused_full = 0;
	int waiting_reads = 0;

	function automatic void free_entry(input int i);
		rob_status[i] = ST_INVALID;
		rob_dest[i] = '0;
		rob_value[i] = '0;
		rob_npc[i] = '0;
	endfunction

	function automatic void shadow_source(input logic [4:0] r, output logic [31:0] v,
			output logic p, output logic [3:0] t);
		v = '0;
		p = 1'b0;
		t = '0;
		if (r != 0) begin
			v = reg_value[r];
			if (reg_pending[r]) begin
				if (rob_status[reg_tag[r]] == ST_DONE) begin
					v = rob_value[reg_tag[r]];
				end else begin
					p = 1'b1;
					t = reg_tag[r];
				end
			end
		end
	endfunction

	// the buffer's update for one item: writeback, source reads, allocation, commit
	function automatic rob_view_t rob_advance(input rob_cmd_t c);
		rob_view_t v;
		logic [3:0] e;
		logic [3:0] o;
		logic [4:0] d;
		entry_status_t st;
		v = '0;
		v.full_res = rob_status[alloc_ptr] != ST_INVALID;
		v.alloc_entry = alloc_ptr;

		e = c.wb_entry;
		if (c.wb_valid && rob_status[e] == ST_EXEC) begin
			if (rob_dest[e] != 0)
				rob_value[e] = c.wb_value;
			rob_status[e] = ST_DONE;
			if (c.wb_next_pc != rob_npc[e]) begin
				rob_status[e] = ST_RESET;
				rob_npc[e] = c.wb_next_pc;
			end
		end

		shadow_source(c.src_a_reg, v.src_a_value, v.src_a_pending, v.src_a_tag);
		shadow_source(c.src_b_reg, v.src_b_value, v.src_b_pending, v.src_b_tag);

		if (c.dispatch_valid && !v.full_res) begin
			d = c.dispatch_dummy ? 5'd0 : c.dispatch_dest;
			rob_status[alloc_ptr] = c.dispatch_dummy ? ST_DUMMY : ST_EXEC;
			rob_npc[alloc_ptr] = c.dispatch_pred_pc;
			rob_value[alloc_ptr] = '0;
			rob_dest[alloc_ptr] = d;
			if (d != 0) begin
				reg_pending[d] = 1'b1;
				reg_tag[d] = alloc_ptr;
			end
			alloc_ptr = alloc_ptr + 4'd1;
		end

		o = retire_ptr;
		st = rob_status[o];
		d = rob_dest[o];
		if (st == ST_DUMMY || st == ST_DONE) begin
			if (st == ST_DONE && d != 0) begin
				reg_value[d] = rob_value[o];
				if (reg_tag[d] == o) begin
					reg_pending[d] = 1'b0;
					reg_tag[d] = '0;
				end
			end
			v.dummy_retired = st == ST_DUMMY;
			free_entry(o);
			retire_ptr = o + 4'd1;
		end else if (st == ST_RESET) begin
			if (d != 0)
				reg_value[d] = rob_value[o];
			v.redirect = 1'b1;
			v.redirect_pc = rob_npc[o];
			for (int r = 0; r < REGS; r++) begin
				reg_pending[r] = 1'b0;
				reg_tag[r] = '0;
			end
			for (int i = 0; i < ENTRIES; i++)
				free_entry(i);
			alloc_ptr = '0;
			retire_ptr = '0;
		end
		return v;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endfunction

	// driver: offers queued items, predicts each one as it is taken
	always @(posedge clk) begin
		rob_cmd_t  taken;
		rob_view_t v;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				taken = rob_cmd_t'(s_tdata);
				v = rob_advance(taken);
				expected_views.push_back(v);
				items_taken++;
				flushes += v.redirect;
				dummy_retires += v.dummy_retired;
				refused_full += taken.dispatch_valid && v.full_res;
				waiting_reads += v.src_a_pending + v.src_b_pending;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_cmds.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: stalls the output at random and checks every result item
	always @(posedge clk) begin
		rob_view_t want;
		rob_view_t got;
		logic hold_now;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = rob_view_t'(m_tdata);
				if (expected_views.size() == 0) begin
					$display("%0t ns: no result expected, got %h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_views.pop_front();
					check_field("full_res", want.full_res, got.full_res);
					check_field("alloc_entry", want.alloc_entry, got.alloc_entry);
					check_field("src_a_value", want.src_a_value, got.src_a_value);
					check_field("src_a_pending", want.src_a_pending, got.src_a_pending);
					check_field("src_a_tag", want.src_a_tag, got.src_a_tag);
					check_field("src_b_value", want.src_b_value, got.src_b_value);
					check_field("src_b_pending", want.src_b_pending, got.src_b_pending);
					check_field("src_b_tag", want.src_b_tag, got.src_b_tag);
					check_field("dummy_retired", want.dummy_retired, got.dummy_retired);
					check_field("redirect", want.redirect, got.redirect);
					check_field("redirect_pc", want.redirect_pc, got.redirect_pc);
				end
			end
			// long hold-off so the block backs up into its input
			hold_now = hold_left != 0 || (hold_request && !hold_taken);
			if (hold_request && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_left <= HOLD_LEN;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
			m_tready <= hold_now ? 1'b0 : ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_MAX) begin
			$display("timeout after %0d cycles without a transfer", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic rob_cmd_t make_cmd(input logic dv, input logic dm, input logic [4:0] dd,
			input logic [15:0] pc, input logic wv, input logic [3:0] we,
			input logic [31:0] wval, input logic [15:0] wpc, input logic [4:0] sa,
			input logic [4:0] sb);
		rob_cmd_t c;
		c = '0;
		c.dispatch_valid = dv;
		c.dispatch_dummy = dm;
		c.dispatch_dest = dd;
		c.dispatch_pred_pc = pc;
		c.wb_valid = wv;
		c.wb_entry = we;
		c.wb_value = wval;
		c.wb_next_pc = wpc;
		c.src_a_reg = sa;
		c.src_b_reg = sb;
		return c;
	endfunction

	// low registers are favored so that sources hit pending tags often
	function automatic logic [4:0] pick_reg();
		int k;
		k = $urandom_range(9);
		if (k == 0)
			return 5'd0;
		else if (k <= 5)
			return 5'($urandom_range(7, 1));
		return 5'($urandom_range(31));
	endfunction

	// mostly writebacks to live entries with the right pc; fill runs only dispatch
	function automatic rob_cmd_t random_cmd(input bit fill_run);
		rob_cmd_t c;
		int busy [$];
		int pick;
		c = '0;
		c.dispatch_valid = fill_run || ($urandom_range(99) < 75);
		c.dispatch_dummy = !fill_run && ($urandom_range(99) < 15);
		c.dispatch_dest = pick_reg();
		c.dispatch_pred_pc = 16'($urandom);
		c.wb_valid = !fill_run && ($urandom_range(99) < 70);
		c.wb_entry = 4'($urandom);
		c.wb_value = $urandom;
		c.wb_next_pc = 16'($urandom);
		for (int i = 0; i < ENTRIES; i++)
			if (rob_status[i] == ST_EXEC)
				busy.push_back(i);
		if (busy.size() != 0 && $urandom_range(99) < 85) begin
			pick = busy[$urandom_range(busy.size() - 1)];
			c.wb_entry = 4'(pick);
			if ($urandom_range(99) >= 6)
				c.wb_next_pc = rob_npc[pick];
		end
		c.src_a_reg = pick_reg();
		c.src_b_reg = pick_reg();
		return c;
	endfunction

	task automatic push_cmd(input rob_cmd_t c);
		while (pending_cmds.size() != 0)
			@(negedge clk);
		pending_cmds.push_back(c);
	endtask

	task automatic wait_drain();
		while (pending_cmds.size() != 0 || s_tvalid || expected_views.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++)
			free_entry(i);
		for (int r = 0; r < REGS; r++) begin
			reg_value[r] = '0;
			reg_pending[r] = 1'b0;
			reg_tag[r] = '0;
		end
		alloc_ptr = '0;
		retire_ptr = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reads at reset, extreme pcs and values, forwarding, dummy retire
		push_cmd(make_cmd(0, 0, 0, 16'h0000, 0, 0, 32'h0, 16'h0, 0, 31));
		push_cmd(make_cmd(1, 0, 31, 16'hFFFF, 0, 0, 32'h0, 16'h0, 31, 0));
		push_cmd(make_cmd(1, 0, 1, 16'h0000, 0, 0, 32'h0, 16'h0, 31, 1));
		push_cmd(make_cmd(1, 1, 31, 16'h1234, 1, 0, 32'hFFFF_FFFF, 16'hFFFF, 31, 1));
		// writeback to a retired entry is dropped; destination zero
		push_cmd(make_cmd(1, 0, 0, 16'h00FF, 1, 0, 32'h5, 16'h0, 31, 1));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 1, 1, 32'hA5A5_A5A5, 16'h0000, 1, 31));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 0, 0, 32'h0, 16'h0, 1, 0));
		push_cmd(make_cmd(1, 0, 5, 16'h1000, 1, 3, 32'hDEAD_BEEF, 16'h00FF, 1, 5));
		// mispredict at the head flushes, same cycle dispatch is lost
		push_cmd(make_cmd(1, 0, 6, 16'h3000, 1, 4, 32'h1234_5678, 16'h2000, 5, 6));
		push_cmd(make_cmd(1, 0, 2, 16'h0040, 0, 0, 32'h0, 16'h0, 5, 6));
		// retag of a register, tag kept when an older producer commits
		push_cmd(make_cmd(1, 0, 2, 16'h0050, 1, 15, 32'h7777_7777, 16'h0, 2, 0));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 1, 0, 32'h1, 16'h0040, 2, 0));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 1, 1, 32'h2, 16'h0050, 2, 0));
		// out of order completion, second writeback to a done entry dropped
		push_cmd(make_cmd(1, 0, 3, 16'h0010, 0, 0, 32'h0, 16'h0, 3, 4));
		push_cmd(make_cmd(1, 0, 4, 16'h0020, 0, 0, 32'h0, 16'h0, 3, 4));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 1, 3, 32'h44, 16'h0020, 3, 4));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 1, 3, 32'h99, 16'h0077, 3, 4));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 1, 2, 32'h33, 16'h0010, 3, 4));
		push_cmd(make_cmd(0, 0, 0, 16'h0, 0, 0, 32'h0, 16'h0, 3, 4));
		wait_drain();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  hold_request = 1'b1; end
				1: begin idle_pct = 62; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 62; end
				default: begin idle_pct = 9; stall_pct = 9; end
			endcase
			for (int n = 0; n < PHASE_LEN; n++)
				push_cmd(random_cmd((n % 80) < FILL_RUN));
			// sender holds back until the block has delivered everything
			wait_drain();
		end

		repeat (10) @(posedge clk);
		$display("ran %0d items: %0d flushes, %0d dummy retirements, %0d dispatches refused",
			items_taken, flushes, dummy_retires, refused_full);
		$display("%0d source reads found their producer still busy", waiting_reads);
		if (expected_views.size() != 0)
			$display("%0d results expected but never delivered", expected_views.size());
		if (errors == 0 && expected_views.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/rrc_pkg.sv
rtl/reorder_buffer_rename_commit.sv
rtl/rrc_checker.sv
test/reorder_buffer_rename_commit_tb.sv
